@@ rtl/core/skf_pkg.sv @@
package skf_pkg;

  // Field widths and fixed-point layout.
  localparam int unsigned SampleW = 16;
  localparam int unsigned DataW   = 32;
  localparam int unsigned GainW   = 25;
  localparam int unsigned FracW   = 24;
  localparam int unsigned ProdW   = DataW + GainW;
  localparam int unsigned AddrW   = 3;

  // One in unsigned Q1.24 and Q8.24.
  localparam logic [DataW-1:0] KfOne = 32'h0100_0000;

  // Reset values of the noise registers and the covariance.
  localparam logic [DataW-1:0] ResetProcessNoise     = 32'd167772;
  localparam logic [DataW-1:0] ResetMeasurementNoise = 32'd76671877;
  localparam logic [DataW-1:0] ResetCovariance       = KfOne;

  // Register index, taken from byte address bit 2.
  typedef enum logic {
    RegProcessNoise     = 1'b0,
    RegMeasurementNoise = 1'b1
  } skf_reg_e;

  // Noise settings handed from the register block to the datapath.
  typedef struct packed {
    logic [DataW-1:0] process_noise;
    logic [DataW-1:0] measurement_noise;
  } skf_cfg_t;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } skf_div_stat_t;

  // Unsigned 32-bit add that saturates at the maximum.
  function automatic logic [DataW-1:0] skf_sat_add(input logic [DataW-1:0] a,
                                                   input logic [DataW-1:0] b);
    logic [DataW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[DataW] ? {DataW{1'b1}} : sum[DataW-1:0];
  endfunction

endpackage

@@ rtl/core/scalar_kalman_filter.sv @@
// Channel   | Direction | Handshake                 | Word
// ----------+-----------+---------------------------+-------------------------------
// input     | in        | in_valid_i / in_stall_o   | sample_i
// output    | out       | out_valid_o / out_stall_i | filtered_value_o, gain_o
// config    | in/out    | APB psel/penable/pready   | process_noise, measurement_noise
//
// From acceptance to its result, one word passes through the 25-step restoring
// divider (skipped when P + R is zero), then two passes through the shared
// multiplier update the estimate and the covariance.
// Reset clears the estimate, sets the covariance to 1.0 and the noise
// registers to their defaults. A stalled result holds the output register while
// the next word is processed, which then waits in write-back until it frees.
module scalar_kalman_filter
  import skf_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [SampleW-1:0] sample_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [DataW-1:0]   filtered_value_o,
  output logic [GainW-1:0]          gain_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [AddrW-1:0]          paddr,
  input  logic [DataW-1:0]          pwdata,
  output logic [DataW-1:0]          prdata,
  output logic                      pready
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_MUL_X,
    ST_UPD_X,
    ST_MUL_P,
    ST_UPD_P,
    ST_WRITE
  } state_e;

  state_e              state_q;
  skf_cfg_t            cfg;
  skf_div_stat_t       div_stat;
  logic [GainW-1:0]    div_quot;
  logic                div_start;
  logic [DataW-1:0]    mul_a;
  logic [GainW-1:0]    mul_b;
  logic [ProdW-1:0]    prod;

  logic [SampleW-1:0]  sample_q;
  logic [DataW-1:0]    denom_q;
  logic [DataW-1:0]    x_q;
  logic [DataW-1:0]    p_q;
  logic [GainW-1:0]    k_q;
  logic [DataW-1:0]    e_mag_q;
  logic                e_neg_q;
  logic                out_valid_q;
  logic [DataW-1:0]    out_value_q;
  logic [GainW-1:0]    out_gain_q;

  logic                in_accept;
  logic                out_free;
  logic [DataW+1:0]    err;
  logic [DataW+1:0]    err_mag;
  logic [ProdW-1:0]    corr_round;
  logic [DataW+1:0]    x_new;
  logic [DataW-1:0]    p_post;

  skf_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  skf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (p_q),
    .divisor_i  (denom_q),
    .quot_o     (div_quot),
    .stat_o     (div_stat)
  );

  skf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign div_start  = (state_q == ST_START) && (denom_q != '0);

  // Innovation z - X as a 34-bit signed value, split into sign and magnitude.
  always_comb begin
    err     = {{2{sample_q[SampleW-1]}}, sample_q, {(DataW-SampleW){1'b0}}}
            - {{2{x_q[DataW-1]}}, x_q};
    err_mag = err[DataW+1] ? (~err + 1'b1) : err;
  end

  // Multiplier operands: K * |e| first, then (1 - K) * P.
  always_comb begin
    unique case (state_q)
      ST_MUL_P: begin
        mul_a = p_q;
        mul_b = KfOne[GainW-1:0] - k_q;
      end
      default: begin
        mul_a = e_mag_q;
        mul_b = k_q;
      end
    endcase
  end

  // Rounded correction, new estimate and floored covariance.
  always_comb begin
    corr_round = prod + ProdW'(KfOne >> 1);
    x_new      = e_neg_q
               ? ({{2{x_q[DataW-1]}}, x_q} - {1'b0, corr_round[ProdW-1:FracW]})
               : ({{2{x_q[DataW-1]}}, x_q} + {1'b0, corr_round[ProdW-1:FracW]});
    p_post     = prod[FracW+DataW-1:FracW];
  end

  // Sequencer, filter state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      x_q         <= '0;
      p_q         <= ResetCovariance;
      k_q         <= '0;
      sample_q    <= '0;
      denom_q     <= '0;
      e_mag_q     <= '0;
      e_neg_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_gain_q  <= '0;
    end else begin
      // The write-back state reloads the output register itself.
      if (out_valid_q && !out_stall_i && (state_q != ST_WRITE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            sample_q <= sample_i;
            denom_q  <= skf_sat_add(p_q, cfg.measurement_noise);
            state_q  <= ST_START;
          end
        end
        ST_START: begin
          e_mag_q <= err_mag[DataW-1:0];
          e_neg_q <= err[DataW+1];
          if (denom_q == '0) begin
            k_q     <= '0;
            state_q <= ST_MUL_X;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_stat.done) begin
            k_q     <= div_quot;
            state_q <= ST_MUL_X;
          end
        end
        ST_MUL_X: state_q <= ST_UPD_X;
        ST_UPD_X: begin
          x_q     <= x_new[DataW-1:0];
          state_q <= ST_MUL_P;
        end
        ST_MUL_P: state_q <= ST_UPD_P;
        ST_UPD_P: begin
          p_q     <= skf_sat_add(p_post, cfg.process_noise);
          state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= x_q;
            out_gain_q  <= k_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_value_q;
  assign gain_o           = out_gain_q;

  // The gain never exceeds one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (gain_o <= KfOne[GainW-1:0]))
    else $error("gain above one");

  // The divider is only started while idle, and only reports during division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> (state_q == ST_DIV))
    else $error("divider done outside division");

  // An accepted word blocks the input on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("input not stalled after acceptance");

  // A new result only appears from the write-back state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(state_q == ST_WRITE))
    else $error("result raised outside write-back");

endmodule

@@ rtl/core/skf_cfg.sv @@
module skf_cfg
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output skf_cfg_t         cfg_o
);

  skf_cfg_t cfg_q;
  skf_reg_e reg_sel;

  // Register index comes from address bit 2; the byte offset bits are ignored.
  assign reg_sel = skf_reg_e'(paddr[2]);
  assign pready  = 1'b1;

  // Writes land at the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.process_noise     <= ResetProcessNoise;
      cfg_q.measurement_noise <= ResetMeasurementNoise;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        RegProcessNoise:     cfg_q.process_noise     <= pwdata;
        RegMeasurementNoise: cfg_q.measurement_noise <= pwdata;
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    unique case (reg_sel)
      RegProcessNoise:     prdata = cfg_q.process_noise;
      RegMeasurementNoise: prdata = cfg_q.measurement_noise;
      default:             prdata = cfg_q.process_noise;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/skf_div.sv @@
module skf_div
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] dividend_i,
  input  logic [DataW-1:0] divisor_i,
  output logic [GainW-1:0] quot_o,
  output skf_div_stat_t    stat_o
);

  // Quotient of dividend * 2^24 / divisor, one bit per cycle. The dividend
  // never exceeds the divisor, so the quotient fits in 25 bits.
  localparam int unsigned CntW = $clog2(GainW);
  localparam logic [CntW-1:0] LastStep = CntW'(GainW - 1);

  logic [DataW-1:0] rem_q, rem_d;
  logic [GainW-1:0] quot_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q, done_q;
  logic [DataW:0]   trial;
  logic [DataW:0]   diff;
  logic             take;

  // The first step compares the dividend itself, later steps shift left.
  always_comb begin
    trial = (cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
    diff  = trial - {1'b0, divisor_i};
    take  = (trial >= {1'b0, divisor_i});
    rem_d = take ? diff[DataW-1:0] : trial[DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= dividend_i;
        quot_q <= '0;
      end else if (busy_q) begin
        rem_q  <= rem_d;
        quot_q <= {quot_q[GainW-2:0], take};
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

@@ rtl/core/skf_mul.sv @@
module skf_mul
  import skf_pkg::*;
(
  input  logic             clk_i,
  input  logic [DataW-1:0] a_i,
  input  logic [GainW-1:0] b_i,
  output logic [ProdW-1:0] prod_o
);

  logic [ProdW-1:0] prod_q;

  // Shared 32x25 unsigned multiplier with a registered product.
  always_ff @(posedge clk_i) begin
    prod_q <= {{GainW{1'b0}}, a_i} * {{DataW{1'b0}}, b_i};
  end

  assign prod_o = prod_q;

endmodule

@@ bench/tb_scalar_kalman_filter.sv @@
module tb_scalar_kalman_filter
  import skf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Run limits and pacing.
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 64;
  localparam int unsigned HoldCycles  = 400;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic [GainW-1:0]        gain;
  } kf_result_t;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #1 clk_i = ~clk_i;

  // Stimulus side of the block.
  logic                      in_valid   = 1'b0;
  logic signed [SampleW-1:0] in_sample  = '0;
  logic                      out_stall  = 1'b0;
  logic                      psel       = 1'b0;
  logic                      penable    = 1'b0;
  logic                      pwrite     = 1'b0;
  logic [AddrW-1:0]          paddr      = '0;
  logic [DataW-1:0]          pwdata     = '0;

  // Outputs of the block.
  logic                      in_stall;
  logic                      out_valid;
  logic signed [DataW-1:0]   filtered_value;
  logic [GainW-1:0]          gain;
  logic [DataW-1:0]          prdata;
  logic                      pready;

  scalar_kalman_filter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .sample_i         (in_sample),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .filtered_value_o (filtered_value),
    .gain_o           (gain),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Samples waiting to be offered, and filter outputs still owed by the block.
  logic signed [SampleW-1:0] sample_backlog [$];
  kf_result_t                kalman_expected [$];

  // Filter state and noise settings as the block should hold them.
  logic signed [DataW-1:0] est_state  = '0;
  logic [DataW-1:0]        cov_state  = ResetCovariance;
  logic [DataW-1:0]        proc_noise = ResetProcessNoise;
  logic [DataW-1:0]        meas_noise = ResetMeasurementNoise;

  // Idling control shared with the driver and the stall process.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req       = 1'b0;
  logic        hold_used      = 1'b0;
  int unsigned hold_left      = 0;

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int          trend_level    = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // One filter step: gain, estimate update, covariance update.
  function automatic kf_result_t kalman_update(input logic signed [SampleW-1:0] z);
    logic [DataW:0]   sum;
    logic [DataW-1:0] denom;
    logic [55:0]      quot;
    logic [GainW-1:0] k;
    longint           x;
    longint           err;
    longint           x_next;
    logic [63:0]      mag;
    logic [63:0]      p_post;
    kf_result_t       res;

    // The denominator P + R saturates at the maximum.
    sum   = {1'b0, cov_state} + {1'b0, meas_noise};
    denom = sum[DataW] ? '1 : sum[DataW-1:0];

    // Gain is floor(P * 2^24 / (P + R)); zero when the denominator is zero.
    k = '0;
    if (denom != '0) begin
      quot = {cov_state, 24'd0} / {24'd0, denom};
      k = (quot > 56'(KfOne)) ? GainW'(KfOne) : quot[GainW-1:0];
    end

    // Correction magnitude rounds half away from zero.
    x   = longint'(est_state);
    err = longint'(z) * 65536 - x;
    mag = (err < 0) ? 64'(-err) : 64'(err);
    mag = (mag * 64'(k) + 64'(KfOne >> 1)) >> FracW;
    x_next = (err < 0) ? x - longint'(mag) : x + longint'(mag);
    if (x_next > longint'(32'sh7fff_ffff)) x_next = longint'(32'sh7fff_ffff);
    if (x_next < longint'(32'sh8000_0000)) x_next = longint'(32'sh8000_0000);
    est_state = DataW'(x_next);

    // Covariance: floor((1 - K) * P), then add Q with saturation.
    p_post = ((64'(KfOne) - 64'(k)) * 64'(cov_state)) >> FracW;
    sum = {1'b0, p_post[DataW-1:0]} + {1'b0, proc_noise};
    cov_state = sum[DataW] ? '1 : sum[DataW-1:0];

    res.value = est_state;
    res.gain  = k;
    return res;
  endfunction

  // Sender: offers the oldest pending sample and holds it until accepted.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        kalman_expected.push_back(kalman_update(in_sample));
        void'(sample_backlog.pop_front());
      end
      if (in_valid && in_stall) begin
        // Stalled word stays as it is.
      end else if (sample_backlog.size() != 0 &&
                   $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        in_sample <= sample_backlog[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off when requested.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_used) begin
      hold_used = 1'b1;
      hold_left = HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: each accepted result word is checked against the oldest prediction.
  always @(posedge clk_i) begin
    kf_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (kalman_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%0d gain=%0d",
                                  filtered_value, gain));
      end else begin
        want = kalman_expected.pop_front();
        if (filtered_value !== want.value) begin
          report_mismatch($sformatf("filtered_value got %0d want %0d",
                                    filtered_value, want.value));
        end
        if (gain !== want.gain) begin
          report_mismatch($sformatf("gain got %0d want %0d", gain, want.gain));
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // APB write, then a read back of the same register.
  task automatic write_noise(input skf_reg_e idx, input logic [DataW-1:0] value);
    logic [AddrW-1:0] addr;
    addr = AddrW'(idx) << 2;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    if (idx == RegProcessNoise) proc_noise = value;
    else meas_noise = value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value) begin
      report_mismatch($sformatf("register %s reads %0h want %0h",
                                idx.name(), prdata, value));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_sent();
    while (sample_backlog.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    wait_sent();
    while (kalman_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Mostly a noisy signal around a level that jumps now and then,
  // with some fully random and some extreme samples mixed in.
  task automatic push_random(input int count);
    int pick;
    int v;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(9);
      if (pick < 2) begin
        v = $signed(16'($urandom));
      end else if (pick == 2) begin
        case ($urandom_range(3))
          0: v = 32767;
          1: v = -32768;
          2: v = 0;
          default: v = -1;
        endcase
      end else begin
        if ($urandom_range(15) == 0) trend_level = $signed(16'($urandom));
        v = trend_level + int'($urandom_range(400)) - 200;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      sample_backlog.push_back(SampleW'(v));
    end
  endtask

  initial begin : stimulus
    logic [DataW-1:0] noise_q [7];
    logic [DataW-1:0] noise_r [7];
    int unsigned      send_pct [4];
    int unsigned      recv_pct [4];

    noise_q  = '{ResetProcessNoise, 32'd0, '1, 32'd0, '1, 32'd0, 32'd0};
    noise_r  = '{ResetMeasurementNoise, 32'd0, '1, '1, 32'd0, 32'd0, 32'd1};
    send_pct = '{0, 65, 0, 10};
    recv_pct = '{0, 0, 65, 10};
    noise_q[5] = $urandom;
    noise_r[5] = $urandom;
    noise_q[6] = $urandom_range(2000000);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words at the reset settings: field extremes, large swings, bit patterns.
    sample_backlog.push_back(16'sd0);
    sample_backlog.push_back(16'sd32767);
    sample_backlog.push_back(16'sd32767);
    sample_backlog.push_back(-16'sd32768);
    sample_backlog.push_back(-16'sd32768);
    sample_backlog.push_back(16'sd1);
    sample_backlog.push_back(-16'sd1);
    sample_backlog.push_back(16'sd32767);
    sample_backlog.push_back(-16'sd32768);
    sample_backlog.push_back(16'sh5555);
    sample_backlog.push_back(16'shAAAA);
    sample_backlog.push_back(16'sd12345);
    sample_backlog.push_back(-16'sd12345);
    sample_backlog.push_back(16'sd0);
    wait_drained();

    // Each noise setting: a short burst of extremes, then the idling phases.
    // Zero noise drives the covariance to zero and so a zero denominator;
    // full-scale noise exercises both saturating sums.
    for (int s = 0; s < 7; s++) begin
      write_noise(RegProcessNoise, noise_q[s]);
      write_noise(RegMeasurementNoise, noise_r[s]);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      sample_backlog.push_back(16'sd32767);
      sample_backlog.push_back(-16'sd32768);
      sample_backlog.push_back(16'sd32767);
      sample_backlog.push_back(16'sd0);
      wait_sent();
      for (int ph = 0; ph < 4; ph++) begin
        send_idle_pct  = send_pct[ph];
        recv_stall_pct = recv_pct[ph];
        // Long receiver hold-off while words keep coming, so the input stalls.
        if (s == 0 && ph == 0) hold_req = 1'b1;
        push_random(34);
        wait_sent();
      end
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ scalar_kalman_filter.f @@
rtl/core/skf_pkg.sv
rtl/core/skf_cfg.sv
rtl/core/skf_div.sv
rtl/core/skf_mul.sv
rtl/core/scalar_kalman_filter.sv
bench/tb_scalar_kalman_filter.sv
